// ===== rtl/core/kdop_pkg.sv =====
// ----------------------------------------------------------------------------
// kdop_pkg
// Shared constants, command codes and types of the k-DOP slab accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package kdop_pkg;

   localparam int MAX_AXES = 8;
   localparam int AXIS_W   = $clog2(MAX_AXES);
   localparam int PROJ_W   = 50;
   localparam int PROD_W   = 48;

   localparam logic signed [PROJ_W-1:0] SLAB_EMPTY_LOW  = {1'b0, {(PROJ_W-1){1'b1}}};
   localparam logic signed [PROJ_W-1:0] SLAB_EMPTY_HIGH = {1'b1, {(PROJ_W-1){1'b0}}};

   localparam logic [2:0] CMD_CLEAR        = 3'd0;
   localparam logic [2:0] CMD_WRITE_NORMAL = 3'd1;
   localparam logic [2:0] CMD_ADD_VERTEX   = 3'd2;
   localparam logic [2:0] CMD_MERGE_SLAB   = 3'd3;
   localparam logic [2:0] CMD_TEST_SLAB    = 3'd4;
   localparam logic [2:0] CMD_READ_SLAB    = 3'd5;

   localparam logic REG_ACTIVE_AXES = 1'b0;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } normal_type;

   typedef struct packed {
      logic signed [PROJ_W-1:0] low;
      logic signed [PROJ_W-1:0] high;
   } slab_entry_type;

   typedef struct packed {
      logic                   en;
      logic [AXIS_W-1:0]      addr;
      slab_entry_type         entry;
   } slab_wr_type;

   typedef enum logic [1:0] {
      DOT_HOLD,
      DOT_FIRST,
      DOT_SECOND,
      DOT_THIRD
   } dot_phase_type;

endpackage

`default_nettype wire

// ===== rtl/core/kdop_slab_accumulator.sv =====
// ----------------------------------------------------------------------------
// kdop_slab_accumulator
// k-DOP slab accumulator: normal table, per-axis slabs, merge and
// separation test, driven by one sequencer around two synchronous memories.
// ----------------------------------------------------------------------------
// Add vertex steps through ST_ADD0 to ST_ADD3 once per axis, from axis 0 to the
// last active axis: the first three drive the shared dot-product unit, the last
// updates that axis's slab. It then passes ST_EXEC like every other command, and
// the result registers are loaded from ST_EXEC. A new request is taken in the cycle
// its predecessor's result is shown, and none while busy. Results cannot
// be stalled. Reset empties all slabs at once, sets the overlap flag and sets
// active_axes to 8; the normal table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module kdop_slab_accumulator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [2:0]                          req_command,
   input  wire logic [2:0]                          req_axis_index,
   input  wire logic signed [31:0]                  req_vertex_x,
   input  wire logic signed [31:0]                  req_vertex_y,
   input  wire logic signed [31:0]                  req_vertex_z,
   input  wire logic signed [15:0]                  req_normal_x,
   input  wire logic signed [15:0]                  req_normal_y,
   input  wire logic signed [15:0]                  req_normal_z,
   input  wire logic signed [kdop_pkg::PROJ_W-1:0]  req_other_min,
   input  wire logic signed [kdop_pkg::PROJ_W-1:0]  req_other_max,
   input  wire logic                                req_last_item,
   output logic                                     rsp_valid,
   output logic signed [kdop_pkg::PROJ_W-1:0]       rsp_slab_min,
   output logic signed [kdop_pkg::PROJ_W-1:0]       rsp_slab_max,
   output logic                                     rsp_overlap,
   output logic                                     rsp_query_done,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [2:0]                          paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import kdop_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADD0,
      ST_ADD1,
      ST_ADD2,
      ST_ADD3
   } state_type;

   state_type                state_ff, state_in;
   logic [3:0]               active_ff;
   logic                     overlap_ff, overlap_in;
   logic [AXIS_W-1:0]        axis_ff;
   logic [AXIS_W-1:0]        req_axis;
   logic                     axis_ok_ff;
   logic [AXIS_W-1:0]        j_ff, j_in;
   logic [AXIS_W-1:0]        last_axis;
   logic [2:0]               cmd_ff;
   logic signed [31:0]       vx_ff, vy_ff, vz_ff;
   normal_type               nrm_ff;
   logic signed [PROJ_W-1:0] omin_ff, omax_ff;
   logic                     last_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PROJ_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [PROJ_W-1:0] rsp_max_ff, rsp_max_in;
   logic                     rsp_ov_ff, rsp_ov_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     accept;
   logic                     cfg_write;
   logic                     nrm_wr_en;
   logic [AXIS_W-1:0]        nrm_raddr;
   normal_type               nrm_rdata;
   logic                     clear_all;
   slab_wr_type              slab_wr;
   logic [AXIS_W-1:0]        slab_raddr;
   slab_entry_type           slab_rdata;
   slab_entry_type           res_entry;
   dot_phase_type            dot_phase;
   logic signed [PROJ_W-1:0] proj;
   logic                     separate;
   logic                     ov_test;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_AXES);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_ACTIVE_AXES) ? {28'd0, active_ff} : 32'd0;
   assign req_axis  = AXIS_W'(req_axis_index);

   always_comb begin
      if (active_ff == 4'd0) begin
         last_axis = '0;
      end else if (int'(active_ff) > MAX_AXES) begin
         last_axis = AXIS_W'(MAX_AXES - 1);
      end else begin
         last_axis = AXIS_W'(active_ff - 4'd1);
      end
   end

   kdop_normal_mem u_normal_mem (
      .clock   (clock),
      .wr_en   (nrm_wr_en),
      .wr_addr (axis_ff),
      .wr_data (nrm_ff),
      .rd_addr (nrm_raddr),
      .rd_data (nrm_rdata)
   );

   kdop_slab_mem u_slab_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr        (slab_wr),
      .rd_addr   (slab_raddr),
      .rd_data   (slab_rdata)
   );

   kdop_dot u_dot (
      .clock    (clock),
      .phase    (dot_phase),
      .vertex_x (vx_ff),
      .vertex_y (vy_ff),
      .vertex_z (vz_ff),
      .normal   (nrm_rdata),
      .proj     (proj)
   );

   assign separate = axis_ok_ff && ((omax_ff < slab_rdata.low) || (omin_ff > slab_rdata.high));
   assign ov_test  = overlap_ff && !separate;

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      overlap_in    = overlap_ff;
      nrm_wr_en     = 1'b0;
      nrm_raddr     = j_ff;
      slab_raddr    = j_ff;
      clear_all     = 1'b0;
      slab_wr.en    = 1'b0;
      slab_wr.addr  = j_ff;
      slab_wr.entry = slab_rdata;
      dot_phase     = DOT_HOLD;
      res_entry     = slab_rdata;
      rsp_valid_in  = 1'b0;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_ov_in     = overlap_ff;
      rsp_done_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            nrm_raddr  = '0;
            slab_raddr = (req_command == CMD_ADD_VERTEX) ? '0 : req_axis;
            j_in       = '0;
            if (accept) begin
               state_in = (req_command == CMD_ADD_VERTEX) ? ST_ADD0 : ST_EXEC;
            end
         end
         ST_ADD0: begin
            dot_phase = DOT_FIRST;
            state_in  = ST_ADD1;
         end
         ST_ADD1: begin
            dot_phase = DOT_SECOND;
            state_in  = ST_ADD2;
         end
         ST_ADD2: begin
            dot_phase = DOT_THIRD;
            state_in  = ST_ADD3;
         end
         ST_ADD3: begin
            slab_wr.en         = 1'b1;
            slab_wr.addr       = j_ff;
            slab_wr.entry.low  = (proj < slab_rdata.low)  ? proj : slab_rdata.low;
            slab_wr.entry.high = (proj > slab_rdata.high) ? proj : slab_rdata.high;
            if (j_ff == last_axis) begin
               slab_raddr = axis_ff;
               state_in   = ST_EXEC;
            end else begin
               j_in       = j_ff + 1'b1;
               nrm_raddr  = j_ff + 1'b1;
               slab_raddr = j_ff + 1'b1;
               state_in   = ST_ADD0;
            end
         end
         ST_EXEC: begin
            slab_raddr   = axis_ff;
            slab_wr.addr = axis_ff;
            unique case (cmd_ff)
               CMD_CLEAR: begin
                  clear_all      = 1'b1;
                  res_entry.low  = SLAB_EMPTY_LOW;
                  res_entry.high = SLAB_EMPTY_HIGH;
               end
               CMD_WRITE_NORMAL: begin
                  nrm_wr_en = axis_ok_ff;
               end
               CMD_MERGE_SLAB: begin
                  res_entry.low  = (omin_ff < slab_rdata.low)  ? omin_ff : slab_rdata.low;
                  res_entry.high = (omax_ff > slab_rdata.high) ? omax_ff : slab_rdata.high;
                  slab_wr.en     = axis_ok_ff;
                  slab_wr.entry  = res_entry;
               end
               CMD_TEST_SLAB: begin
                  rsp_ov_in   = ov_test;
                  rsp_done_in = last_ff;
                  overlap_in  = last_ff ? 1'b1 : ov_test;
               end
               default: begin
               end
            endcase
            rsp_valid_in = 1'b1;
            rsp_min_in   = axis_ok_ff ? res_entry.low  : '0;
            rsp_max_in   = axis_ok_ff ? res_entry.high : '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         overlap_ff   <= 1'b1;
         active_ff    <= 4'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overlap_ff   <= overlap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            active_ff <= pwdata[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_done_ff <= rsp_done_in;
      if (accept) begin
         cmd_ff     <= req_command;
         axis_ff    <= req_axis;
         axis_ok_ff <= int'(req_axis_index) < MAX_AXES;
         vx_ff      <= req_vertex_x;
         vy_ff      <= req_vertex_y;
         vz_ff      <= req_vertex_z;
         nrm_ff.x   <= req_normal_x;
         nrm_ff.y   <= req_normal_y;
         nrm_ff.z   <= req_normal_z;
         omin_ff    <= req_other_min;
         omax_ff    <= req_other_max;
         last_ff    <= req_last_item;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slab_min   = rsp_min_ff;
   assign rsp_slab_max   = rsp_max_ff;
   assign rsp_overlap    = rsp_ov_ff;
   assign rsp_query_done = rsp_done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kdop_normal_mem.sv =====
// ----------------------------------------------------------------------------
// kdop_normal_mem
// Normal table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kdop_normal_mem (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [kdop_pkg::AXIS_W-1:0]     wr_addr,
   input  wire kdop_pkg::normal_type            wr_data,
   input  wire logic [kdop_pkg::AXIS_W-1:0]     rd_addr,
   output kdop_pkg::normal_type                 rd_data
);
   import kdop_pkg::*;

   normal_type mem [MAX_AXES];
   normal_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kdop_slab_mem.sv =====
// ----------------------------------------------------------------------------
// kdop_slab_mem
// Slab table with per-entry valid bits that clear every entry at once and
// write-to-read forwarding for same-entry accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module kdop_slab_mem (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear_all,
   input  wire kdop_pkg::slab_wr_type           wr,
   input  wire logic [kdop_pkg::AXIS_W-1:0]     rd_addr,
   output kdop_pkg::slab_entry_type             rd_data
);
   import kdop_pkg::*;

   slab_entry_type      mem [MAX_AXES];
   slab_entry_type      rd_entry_ff;
   slab_entry_type      fwd_entry_ff;
   logic                rd_valid_ff;
   logic                fwd_ff;
   logic [MAX_AXES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_entry_ff  <= mem[rd_addr];
      rd_valid_ff  <= valid_ff[rd_addr];
      fwd_ff       <= wr.en && (wr.addr == rd_addr);
      fwd_entry_ff <= wr.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear_all) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_entry_ff;
      end else if (rd_valid_ff) begin
         rd_data = rd_entry_ff;
      end else begin
         rd_data.low  = SLAB_EMPTY_LOW;
         rd_data.high = SLAB_EMPTY_HIGH;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/kdop_dot.sv =====
// ----------------------------------------------------------------------------
// kdop_dot
// Shared dot-product unit: one 32x16 multiply per cycle in the first to third
// phases, accumulated over those three phases into a Q20.30 projection.
// ----------------------------------------------------------------------------
`default_nettype none

module kdop_dot (
   input  wire logic                                   clock,
   input  wire kdop_pkg::dot_phase_type                phase,
   input  wire logic signed [31:0]                     vertex_x,
   input  wire logic signed [31:0]                     vertex_y,
   input  wire logic signed [31:0]                     vertex_z,
   input  wire kdop_pkg::normal_type                   normal,
   output logic signed [kdop_pkg::PROJ_W-1:0]          proj
);
   import kdop_pkg::*;

   logic signed [31:0]       mul_a;
   logic signed [15:0]       mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROJ_W-1:0] prod_ext;
   logic signed [PROJ_W-1:0] acc_ff;

   always_comb begin
      unique case (phase)
         DOT_SECOND: begin
            mul_a = vertex_y;
            mul_b = normal.y;
         end
         DOT_THIRD: begin
            mul_a = vertex_z;
            mul_b = normal.z;
         end
         default: begin
            mul_a = vertex_x;
            mul_b = normal.x;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(PROJ_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign proj     = acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      unique case (phase)
         DOT_FIRST: begin
            prod_ff <= prod_in;
         end
         DOT_SECOND: begin
            prod_ff <= prod_in;
            acc_ff  <= prod_ext;
         end
         DOT_THIRD: begin
            prod_ff <= prod_in;
            acc_ff  <= acc_ff + prod_ext;
         end
         DOT_HOLD: begin
         end
      endcase
   end

endmodule

`default_nettype wire
